@@ hw/rtl/dpb_pkg.sv @@
// ============================================================================
// dpb_pkg
// Shared widths, register map, payload types and saturation helper for the
// depth pixel back-projection block.
// ============================================================================
package dpb_pkg;

    localparam int PIX_W     = 12;
    localparam int DEPTH_W   = 16;
    localparam int COLOR_W   = 8;
    localparam int WORLD_W   = 32;
    localparam int RECIP_W   = 25;
    localparam int HALF_W    = 16;
    localparam int COEF_W    = 16;
    localparam int POSE_W    = 64;
    localparam int PP_W      = 32;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;
    localparam int REG_LSB    = 3;

    // Signed half-pixel offset; holds 2u - cx for 12-bit coordinates and a 16-bit cx.
    localparam int DX_W      = 18;
    localparam int RXP_W     = DX_W + RECIP_W + 1;
    localparam int RX_SHIFT  = 11;
    localparam int RX_W      = 32;
    localparam int ZP_W      = DEPTH_W + RECIP_W;
    localparam int Z_SHIFT   = 8;
    localparam int ZQ_W      = ZP_W + 1 - Z_SHIFT;
    localparam int Z_W       = 31;
    localparam int CAM_W     = 64;
    localparam int Q_SHIFT   = 14;
    localparam int PPROD_W   = COEF_W + WORLD_W;
    localparam int T_SHIFT   = 20;
    localparam int ACC_W     = 51;

    localparam logic [REG_IDX_W-1:0] REG_POSE_X    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POSE_Y    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_POSE_Z    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PRINCIPAL = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INV_FX    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INV_FY    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INV_DS    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DEPTH = 3'd7;

    localparam logic [POSE_W-1:0]  RST_POSE_X    = 64'h4000_0000_0000_0000;
    localparam logic [POSE_W-1:0]  RST_POSE_Y    = 64'h0000_4000_0000_0000;
    localparam logic [POSE_W-1:0]  RST_POSE_Z    = 64'h0000_0000_4000_0000;
    localparam logic [PP_W-1:0]    RST_PRINCIPAL = 32'h028B_01FB;
    localparam logic [RECIP_W-1:0] RST_INV_FX    = 25'd32388;
    localparam logic [RECIP_W-1:0] RST_INV_FY    = 25'd32326;
    localparam logic [RECIP_W-1:0] RST_INV_DS    = 25'd16777;
    localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH = 16'd7000;

    typedef struct packed {
        logic [POSE_W-1:0]  pose_x;
        logic [POSE_W-1:0]  pose_y;
        logic [POSE_W-1:0]  pose_z;
        logic [PP_W-1:0]    principal;
        logic [RECIP_W-1:0] inv_fx;
        logic [RECIP_W-1:0] inv_fy;
        logic [RECIP_W-1:0] inv_ds;
        logic [DEPTH_W-1:0] max_depth;
    } t_cfg;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_color;

    typedef struct packed {
        logic [PIX_W-1:0]   column;
        logic [PIX_W-1:0]   row;
        logic [DEPTH_W-1:0] raw_depth;
        t_color             color;
    } t_pixel;

    typedef struct packed {
        logic signed [WORLD_W-1:0] x;
        logic signed [WORLD_W-1:0] y;
        logic signed [WORLD_W-1:0] z;
        t_color                    color;
    } t_point;

    function automatic logic signed [WORLD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return hi[WORLD_W-1:0];
        end else if (v < lo) begin
            return lo[WORLD_W-1:0];
        end
        return v[WORLD_W-1:0];
    endfunction

endpackage

@@ hw/rtl/dpb_if.sv @@
// ============================================================================
// dpb_if
// Valid/ready channels for input pixels and output world points.
// ============================================================================
interface dpb_pixel_if import dpb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   column;
    logic [PIX_W-1:0]   row;
    logic [DEPTH_W-1:0] raw_depth;
    logic [COLOR_W-1:0] blue_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] red_in;

    modport source (
        output valid, column, row, raw_depth, blue_in, green_in, red_in,
        input  ready
    );
    modport sink (
        input  valid, column, row, raw_depth, blue_in, green_in, red_in,
        output ready
    );
endinterface

interface dpb_point_if import dpb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic signed [WORLD_W-1:0] world_z;
    logic [COLOR_W-1:0]        blue_out;
    logic [COLOR_W-1:0]        green_out;
    logic [COLOR_W-1:0]        red_out;

    modport source (
        output valid, world_x, world_y, world_z, blue_out, green_out, red_out,
        input  ready
    );
    modport sink (
        input  valid, world_x, world_y, world_z, blue_out, green_out, red_out,
        output ready
    );
endinterface

@@ hw/rtl/dpb_cfg_regs.sv @@
// ============================================================================
// dpb_cfg_regs
// APB register file holding the camera intrinsics, depth limits and pose.
// ============================================================================
module dpb_cfg_regs import dpb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[REG_LSB +: REG_IDX_W];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pose_x    <= RST_POSE_X;
            r_cfg.pose_y    <= RST_POSE_Y;
            r_cfg.pose_z    <= RST_POSE_Z;
            r_cfg.principal <= RST_PRINCIPAL;
            r_cfg.inv_fx    <= RST_INV_FX;
            r_cfg.inv_fy    <= RST_INV_FY;
            r_cfg.inv_ds    <= RST_INV_DS;
            r_cfg.max_depth <= RST_MAX_DEPTH;
        end else if (w_wr) begin
            case (w_idx)
                REG_POSE_X:    r_cfg.pose_x    <= pwdata;
                REG_POSE_Y:    r_cfg.pose_y    <= pwdata;
                REG_POSE_Z:    r_cfg.pose_z    <= pwdata;
                REG_PRINCIPAL: r_cfg.principal <= pwdata[PP_W-1:0];
                REG_INV_FX:    r_cfg.inv_fx    <= pwdata[RECIP_W-1:0];
                REG_INV_FY:    r_cfg.inv_fy    <= pwdata[RECIP_W-1:0];
                REG_INV_DS:    r_cfg.inv_ds    <= pwdata[RECIP_W-1:0];
                default:       r_cfg.max_depth <= pwdata[DEPTH_W-1:0];
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_POSE_X:    prdata = r_cfg.pose_x;
            REG_POSE_Y:    prdata = r_cfg.pose_y;
            REG_POSE_Z:    prdata = r_cfg.pose_z;
            REG_PRINCIPAL: prdata = APB_DATA_W'(r_cfg.principal);
            REG_INV_FX:    prdata = APB_DATA_W'(r_cfg.inv_fx);
            REG_INV_FY:    prdata = APB_DATA_W'(r_cfg.inv_fy);
            REG_INV_DS:    prdata = APB_DATA_W'(r_cfg.inv_ds);
            default:       prdata = APB_DATA_W'(r_cfg.max_depth);
        endcase
    end

endmodule

@@ hw/rtl/dpb_camera.sv @@
// ============================================================================
// dpb_camera
// Three-stage pipeline from a depth pixel to a saturated camera-frame point:
// depth scaling and ray scaling, ray times depth, then rounding and clamping.
// ============================================================================
module dpb_camera import dpb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_pixel i_pixel,
    output logic   o_valid,
    input  logic   i_ready,
    output t_point o_point
);

    localparam logic signed [RXP_W-1:0] RX_HALF  = RXP_W'(1 << (RX_SHIFT - 1));
    localparam logic signed [CAM_W-1:0] CAM_HALF = CAM_W'(1 << (Q_SHIFT - 1));
    localparam logic [ZQ_W-1:0]         Z_MAX    = ZQ_W'({Z_W{1'b1}});

    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    logic signed [DX_W-1:0]  w_dx, w_dy;
    logic signed [RXP_W-1:0] w_prod_x, w_prod_y, w_sum_x, w_sum_y;
    logic [ZP_W-1:0]         w_zp;
    logic [ZP_W:0]           w_zr;
    logic [ZQ_W-1:0]         w_zq;
    logic [Z_W-1:0]          w_z;
    logic                    w_keep;

    logic signed [RX_W-1:0]  r1_rx, r1_ry;
    logic [Z_W-1:0]          r1_z;
    t_color                  r1_color;

    logic signed [CAM_W-1:0] r2_px, r2_py;
    logic [Z_W-1:0]          r2_z;
    t_color                  r2_color;

    logic signed [CAM_W-1:0] w_sx, w_sy, w_shx, w_shy;
    t_point                  r3_point;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v3;
    assign o_point = r3_point;

    always_comb begin
        w_dx = $signed({{(DX_W-PIX_W-1){1'b0}}, i_pixel.column, 1'b0})
             - $signed({{(DX_W-HALF_W){1'b0}}, i_cfg.principal[PP_W-1 -: HALF_W]});
        w_dy = $signed({{(DX_W-PIX_W-1){1'b0}}, i_pixel.row, 1'b0})
             - $signed({{(DX_W-HALF_W){1'b0}}, i_cfg.principal[HALF_W-1:0]});
        w_prod_x = w_dx * $signed({1'b0, i_cfg.inv_fx});
        w_prod_y = w_dy * $signed({1'b0, i_cfg.inv_fy});
        w_sum_x  = w_prod_x + RX_HALF;
        w_sum_y  = w_prod_y + RX_HALF;
        w_zp     = i_pixel.raw_depth * i_cfg.inv_ds;
        w_zr     = {1'b0, w_zp} + (ZP_W + 1)'(1 << (Z_SHIFT - 1));
        w_zq     = w_zr[ZP_W:Z_SHIFT];
        w_z      = (w_zq > Z_MAX) ? {Z_W{1'b1}} : w_zq[Z_W-1:0];
        w_keep   = (i_pixel.raw_depth != '0) && (i_pixel.raw_depth < i_cfg.max_depth);
    end

    always_comb begin
        w_sx  = r2_px + CAM_HALF;
        w_sy  = r2_py + CAM_HALF;
        w_shx = w_sx >>> Q_SHIFT;
        w_shy = w_sy >>> Q_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid && w_keep;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_rx    <= w_sum_x[RX_SHIFT +: RX_W];
            r1_ry    <= w_sum_y[RX_SHIFT +: RX_W];
            r1_z     <= w_z;
            r1_color <= i_pixel.color;
        end
        if (w_en2) begin
            r2_px    <= r1_rx * $signed({1'b0, r1_z});
            r2_py    <= r1_ry * $signed({1'b0, r1_z});
            r2_z     <= r1_z;
            r2_color <= r1_color;
        end
        if (w_en3) begin
            r3_point.x     <= sat32(w_shx);
            r3_point.y     <= sat32(w_shy);
            r3_point.z     <= $signed({1'b0, r2_z});
            r3_point.color <= r2_color;
        end
    end

endmodule

@@ hw/rtl/dpb_pose.sv @@
// ============================================================================
// dpb_pose
// Three-stage pipeline applying the rigid pose: nine coefficient products,
// row sums with translation and rounding, then shift and saturation.
// ============================================================================
module dpb_pose import dpb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_point i_point,
    output logic   o_valid,
    input  logic   i_ready,
    output t_point o_point
);

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1 << (Q_SHIFT - 1));

    logic r_v4, r_v5, r_v6;
    logic w_en4, w_en5, w_en6;

    logic [POSE_W-1:0]         w_rows [3];
    logic signed [WORLD_W-1:0] w_p    [3];
    logic signed [PPROD_W-1:0] w_prod [3][3];
    logic signed [ACC_W-1:0]   w_t    [3];
    logic signed [ACC_W-1:0]   w_acc  [3];
    logic signed [63:0]        w_sh   [3];

    logic signed [PPROD_W-1:0] r4_prod [3][3];
    t_color                    r4_color;
    logic signed [ACC_W-1:0]   r5_acc  [3];
    t_color                    r5_color;
    t_point                    r6_point;

    assign w_en6   = !r_v6 || i_ready;
    assign w_en5   = !r_v5 || w_en6;
    assign w_en4   = !r_v4 || w_en5;
    assign o_ready = w_en4;
    assign o_valid = r_v6;
    assign o_point = r6_point;

    assign w_rows[0] = i_cfg.pose_x;
    assign w_rows[1] = i_cfg.pose_y;
    assign w_rows[2] = i_cfg.pose_z;
    assign w_p[0]    = i_point.x;
    assign w_p[1]    = i_point.y;
    assign w_p[2]    = i_point.z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                w_prod[k][j] = $signed(w_rows[k][POSE_W-1-COEF_W*j -: COEF_W]) * w_p[j];
            end
            w_t[k] = $signed({{(ACC_W-COEF_W-T_SHIFT){w_rows[k][COEF_W-1]}},
                              w_rows[k][COEF_W-1:0], {T_SHIFT{1'b0}}});
            w_acc[k] = r4_prod[k][0] + r4_prod[k][1] + r4_prod[k][2] + w_t[k] + ACC_HALF;
            w_sh[k]  = 64'(r5_acc[k]) >>> Q_SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en4) begin
                r_v4 <= i_valid;
            end
            if (w_en5) begin
                r_v5 <= r_v4;
            end
            if (w_en6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_prod  <= w_prod;
            r4_color <= i_point.color;
        end
        if (w_en5) begin
            r5_acc   <= w_acc;
            r5_color <= r4_color;
        end
        if (w_en6) begin
            r6_point.x     <= sat32(w_sh[0]);
            r6_point.y     <= sat32(w_sh[1]);
            r6_point.z     <= sat32(w_sh[2]);
            r6_point.color <= r5_color;
        end
    end

endmodule

@@ hw/rtl/depth_pixel_backprojection.sv @@
// Throughput: one pixel per cycle through six pipeline registers while the output
// accepts; each stage advances whenever it is empty or the stage after it moves.
// Pixels with zero depth or depth at or above max_depth leave no result.
// Reset clears all pipeline valid bits and loads the default calibration and pose.
// ============================================================================
// depth_pixel_backprojection
// Back-projects depth pixels through a pinhole model and a rigid pose into
// saturated Q15.16 world points, with the color carried alongside.
// ============================================================================
module depth_pixel_backprojection import dpb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    dpb_pixel_if.sink             i_pixel,
    dpb_point_if.source           o_point
);

    t_cfg   w_cfg;
    t_pixel w_pixel;
    t_point w_cam_point;
    t_point w_world;
    logic   w_cam_valid;
    logic   w_pose_ready;

    assign w_pixel.column      = i_pixel.column;
    assign w_pixel.row         = i_pixel.row;
    assign w_pixel.raw_depth   = i_pixel.raw_depth;
    assign w_pixel.color.blue  = i_pixel.blue_in;
    assign w_pixel.color.green = i_pixel.green_in;
    assign w_pixel.color.red   = i_pixel.red_in;

    dpb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dpb_camera u_camera (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_pixel.valid),
        .o_ready (i_pixel.ready),
        .i_pixel (w_pixel),
        .o_valid (w_cam_valid),
        .i_ready (w_pose_ready),
        .o_point (w_cam_point)
    );

    dpb_pose u_pose (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_cam_valid),
        .o_ready (w_pose_ready),
        .i_point (w_cam_point),
        .o_valid (o_point.valid),
        .i_ready (o_point.ready),
        .o_point (w_world)
    );

    assign o_point.world_x   = w_world.x;
    assign o_point.world_y   = w_world.y;
    assign o_point.world_z   = w_world.z;
    assign o_point.blue_out  = w_world.color.blue;
    assign o_point.green_out = w_world.color.green;
    assign o_point.red_out   = w_world.color.red;

endmodule

@@ tb/tb_depth_pixel_backprojection.sv @@
// ============================================================================
// tb_depth_pixel_backprojection
// Self-checking bench for the depth pixel back-projection block. Pixels are
// sent over the valid/ready input channel and calibration is loaded over the
// APB port between phases while the pipeline is empty. A directed set of
// pixels under fixed calibrations comes first. Seeded random phases follow,
// each with a random calibration. Every output point is compared field by
// field against a typed-in value or a fixed-point projection computed in the bench.
// ============================================================================
module tb_depth_pixel_backprojection;
    timeunit 1ns;
    timeprecision 1ps;
    import dpb_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_KEPT    = 190;
    localparam int PHASE_CAP     = 240;
    localparam logic [COEF_W-1:0] COEF_ONE = 16'h4000;

    typedef enum int {
        SET_RESET,
        SET_UNIT,
        SET_POS_EXT,
        SET_NEG_EXT,
        SET_DROP_ALL,
        SET_RANDOM
    } t_setting;

    typedef struct {
        t_setting                  setting;
        t_pixel                    px;
        bit                        pinned;
        bit                        pin_keep;
        logic signed [WORLD_W-1:0] pin_x;
        logic signed [WORLD_W-1:0] pin_y;
        logic signed [WORLD_W-1:0] pin_z;
    } t_case;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dpb_pixel_if pix_if ();
    dpb_point_if pt_if ();

    depth_pixel_backprojection uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pixel (pix_if),
        .o_point (pt_if)
    );

    t_cfg   cal;
    t_point pending_points[$];
    t_point head_point;
    int     mismatches;
    int     quiet_cycles;
    int     src_gap_pct;
    int     snk_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_s32(longint v);
        if (v > longint'(32'h7FFF_FFFF)) begin
            return longint'(32'h7FFF_FFFF);
        end
        if (v < -longint'(32'h8000_0000)) begin
            return -longint'(32'h8000_0000);
        end
        return v;
    endfunction

    function automatic logic signed [WORLD_W-1:0] rotate_row(logic [POSE_W-1:0] r,
                                                             longint cx, longint cy,
                                                             longint cz);
        longint acc;
        acc = longint'($signed(r[63:48])) * cx + longint'($signed(r[47:32])) * cy
            + longint'($signed(r[31:16])) * cz
            + longint'($signed(r[15:0])) * (longint'(1) <<< T_SHIFT);
        return WORLD_W'(clamp_s32(round_half_up(acc, Q_SHIFT)));
    endfunction

    function automatic bit project_pixel(t_pixel px, t_cfg c, output t_point pt);
        longint z;
        longint dx;
        longint dy;
        longint rx;
        longint ry;
        longint x;
        longint y;
        pt = '0;
        if (px.raw_depth == 0 || px.raw_depth >= c.max_depth) begin
            return 1'b0;
        end
        z = (longint'(px.raw_depth) * longint'(c.inv_ds) + 128) >>> Z_SHIFT;
        if (z > longint'(32'h7FFF_FFFF)) begin
            z = longint'(32'h7FFF_FFFF);
        end
        dx = 2 * longint'(px.column) - longint'(c.principal[31:16]);
        dy = 2 * longint'(px.row) - longint'(c.principal[15:0]);
        rx = round_half_up(dx * longint'(c.inv_fx), RX_SHIFT);
        ry = round_half_up(dy * longint'(c.inv_fy), RX_SHIFT);
        x = clamp_s32(round_half_up(rx * z, Q_SHIFT));
        y = clamp_s32(round_half_up(ry * z, Q_SHIFT));
        pt.x = rotate_row(c.pose_x, x, y, z);
        pt.y = rotate_row(c.pose_y, x, y, z);
        pt.z = rotate_row(c.pose_z, x, y, z);
        pt.color = px.color;
        return 1'b1;
    endfunction

    function automatic logic [POSE_W-1:0] random_pose_row(int axis);
        logic [POSE_W-1:0] r;
        logic [COEF_W-1:0] co[3];
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
            foreach (co[k]) begin
                co[k] = 16'($urandom_range(0, 32768)) - 16'd16384;
            end
            r = {co[0], co[1], co[2], 16'($urandom)};
        end else if (pick <= 6) begin
            r = '0;
            r[63 - 16 * axis -: 16] = COEF_ONE;
            r[15:0] = 16'($urandom_range(0, 4096)) - 16'd2048;
        end else if (pick == 7) begin
            r = {$urandom, $urandom};
        end else if (pick == 8) begin
            r = {4{16'h7FFF}};
        end else begin
            r = {4{16'h8000}};
        end
        return r;
    endfunction

    function automatic logic [RECIP_W-1:0] random_recip(int lo, int hi);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 25'h100_0000;
            3: return 25'($urandom);
            default: return 25'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic t_cfg setting_cfg(t_setting s);
        t_cfg c;
        c = {RST_POSE_X, RST_POSE_Y, RST_POSE_Z, RST_PRINCIPAL,
             RST_INV_FX, RST_INV_FY, RST_INV_DS, RST_MAX_DEPTH};
        case (s)
            SET_UNIT: begin
                c.pose_x    = {COEF_ONE, 48'h0};
                c.pose_y    = {16'h0, COEF_ONE, 32'h0};
                c.pose_z    = {32'h0, COEF_ONE, 16'h0};
                c.principal = '0;
                c.inv_fx    = '0;
                c.inv_fy    = '0;
                c.inv_ds    = 25'd256;
                c.max_depth = '1;
            end
            SET_POS_EXT: begin
                c.pose_x    = {4{16'h7FFF}};
                c.pose_y    = {4{16'h7FFF}};
                c.pose_z    = {4{16'h7FFF}};
                c.principal = '0;
                c.inv_fx    = '1;
                c.inv_fy    = '1;
                c.inv_ds    = '1;
                c.max_depth = '1;
            end
            SET_NEG_EXT: begin
                c.pose_x    = {4{16'h8000}};
                c.pose_y    = {4{16'h8000}};
                c.pose_z    = {4{16'h8000}};
                c.principal = '1;
                c.inv_fx    = '1;
                c.inv_fy    = '1;
                c.inv_ds    = '1;
                c.max_depth = '1;
            end
            SET_DROP_ALL: begin
                c.max_depth = '0;
            end
            SET_RANDOM: begin
                c.pose_x = random_pose_row(0);
                c.pose_y = random_pose_row(1);
                c.pose_z = random_pose_row(2);
                case ($urandom_range(0, 7))
                    0: c.principal = '0;
                    1: c.principal = '1;
                    2: c.principal = $urandom;
                    default: c.principal = {16'($urandom_range(0, 8190)),
                                            16'($urandom_range(0, 8190))};
                endcase
                c.inv_fx = random_recip(8000, 90000);
                c.inv_fy = random_recip(8000, 90000);
                c.inv_ds = random_recip(1000, 70000);
                case ($urandom_range(0, 9))
                    0: c.max_depth = '0;
                    1: c.max_depth = 16'd1;
                    2: c.max_depth = '1;
                    default: c.max_depth = 16'($urandom_range(500, 65535));
                endcase
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    function automatic logic [DEPTH_W-1:0] random_depth(logic [DEPTH_W-1:0] maxd);
        case ($urandom_range(0, 19))
            0: return '0;
            1: return maxd;
            2: return (maxd > 1) ? maxd - 16'd1 : 16'd1;
            3: return '1;
            4: return 16'($urandom);
            default: return (maxd > 1) ? 16'($urandom_range(1, maxd - 1)) : 16'($urandom);
        endcase
    endfunction

    function automatic t_case dir_case(t_setting s, int u, int v, int d,
                                       logic [23:0] bgr, bit pinned, bit keep,
                                       int x, int y, int z);
        t_case t;
        t.setting  = s;
        t.px       = {12'(u), 12'(v), 16'(d), bgr};
        t.pinned   = pinned;
        t.pin_keep = keep;
        t.pin_x    = x;
        t.pin_y    = y;
        t.pin_z    = z;
        return t;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("%0t ERROR %s", $time, what);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << REG_LSB;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_calibration(t_cfg c);
        apb_write(REG_POSE_X, c.pose_x);
        apb_write(REG_POSE_Y, c.pose_y);
        apb_write(REG_POSE_Z, c.pose_z);
        apb_write(REG_PRINCIPAL, APB_DATA_W'(c.principal));
        apb_write(REG_INV_FX, APB_DATA_W'(c.inv_fx));
        apb_write(REG_INV_FY, APB_DATA_W'(c.inv_fy));
        apb_write(REG_INV_DS, APB_DATA_W'(c.inv_ds));
        apb_write(REG_MAX_DEPTH, APB_DATA_W'(c.max_depth));
        cal = c;
    endtask

    task automatic wait_idle(int settle);
        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_points.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic send_pixel(t_pixel px, bit pinned, bit pin_keep, t_point pin_pt,
                              output bit kept);
        t_point pt;
        pix_if.valid     <= 1'b1;
        pix_if.column    <= px.column;
        pix_if.row       <= px.row;
        pix_if.raw_depth <= px.raw_depth;
        pix_if.blue_in   <= px.color.blue;
        pix_if.green_in  <= px.color.green;
        pix_if.red_in    <= px.color.red;
        do @(posedge i_clk); while (!pix_if.ready);
        if (pinned) begin
            kept = pin_keep;
            pt = pin_pt;
        end else begin
            kept = project_pixel(px, cal, pt);
        end
        if (kept) begin
            pending_points = {pending_points, pt};
        end
        if ($urandom_range(0, 99) < src_gap_pct) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    initial begin
        pt_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) < snk_stall_pct) begin
                pt_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                pt_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pix_if.valid && pix_if.ready) || (pt_if.valid && pt_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (pt_if.valid && pt_if.ready) begin
                if (pending_points.size() == 0) begin
                    report_mismatch("output transaction with no pixel pending");
                end else begin
                    head_point = pending_points.pop_front();
                    if (pt_if.world_x !== head_point.x) begin
                        report_mismatch($sformatf("world_x got %0d expected %0d",
                                                  pt_if.world_x, head_point.x));
                    end
                    if (pt_if.world_y !== head_point.y) begin
                        report_mismatch($sformatf("world_y got %0d expected %0d",
                                                  pt_if.world_y, head_point.y));
                    end
                    if (pt_if.world_z !== head_point.z) begin
                        report_mismatch($sformatf("world_z got %0d expected %0d",
                                                  pt_if.world_z, head_point.z));
                    end
                    if (pt_if.blue_out !== head_point.color.blue) begin
                        report_mismatch($sformatf("blue_out got %0h expected %0h",
                                                  pt_if.blue_out, head_point.color.blue));
                    end
                    if (pt_if.green_out !== head_point.color.green) begin
                        report_mismatch($sformatf("green_out got %0h expected %0h",
                                                  pt_if.green_out, head_point.color.green));
                    end
                    if (pt_if.red_out !== head_point.color.red) begin
                        report_mismatch($sformatf("red_out got %0h expected %0h",
                                                  pt_if.red_out, head_point.color.red));
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        t_case    cases[$];
        t_pixel   px;
        t_point   pin_pt;
        t_setting cur;
        bit       kept;
        int       sent;
        int       kept_n;
        mismatches    = 0;
        quiet_cycles  = 0;
        src_gap_pct   = 10;
        snk_stall_pct = 5;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        pix_if.valid     <= 1'b0;
        pix_if.column    <= '0;
        pix_if.row       <= '0;
        pix_if.raw_depth <= '0;
        pix_if.blue_in   <= '0;
        pix_if.green_in  <= '0;
        pix_if.red_in    <= '0;

        // Reset calibration: drops are typed in, kept pixels go through the projection.
        cases = {cases, dir_case(SET_RESET, 0, 0, 0, 24'h000000, 1, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_RESET, 325, 253, 7000, 24'h123456, 1, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_RESET, 4095, 4095, 65535, 24'hFFFFFF, 1, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_RESET, 0, 0, 1, 24'hFF00FF, 0, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_RESET, 4095, 4095, 6999, 24'hAA550F, 0, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_RESET, 325, 253, 1000, 24'h00FF00, 0, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_RESET, 4095, 0, 3000, 24'h5A5A5A, 0, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_RESET, 0, 4095, 500, 24'hA5A5A5, 0, 0, 0, 0, 0)};
        // Identity pose, zero ray slope and unit depth scale: a kept pixel gives (0, 0, depth).
        cases = {cases, dir_case(SET_UNIT, 0, 0, 1, 24'h123456, 1, 1, 0, 0, 1)};
        cases = {cases, dir_case(SET_UNIT, 4095, 4095, 65534, 24'hFFFFFF, 1, 1, 0, 0, 65534)};
        cases = {cases, dir_case(SET_UNIT, 100, 200, 65535, 24'h010203, 1, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_UNIT, 2048, 1024, 1000, 24'h800080, 1, 1, 0, 0, 1000)};
        cases = {cases, dir_case(SET_POS_EXT, 4095, 4095, 65534, 24'hFFFFFF, 0, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_POS_EXT, 0, 0, 1, 24'h000000, 0, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_POS_EXT, 2048, 0, 30000, 24'h7F7F7F, 0, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_NEG_EXT, 0, 0, 65534, 24'h808080, 0, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_NEG_EXT, 4095, 4095, 1, 24'h0F0F0F, 0, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_NEG_EXT, 1000, 3000, 40000, 24'hF0F0F0, 0, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_DROP_ALL, 0, 0, 1, 24'h112233, 1, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_DROP_ALL, 4095, 4095, 65535, 24'h445566, 1, 0, 0, 0, 0)};
        cases = {cases, dir_case(SET_DROP_ALL, 100, 100, 7000, 24'h778899, 1, 0, 0, 0, 0)};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cal = setting_cfg(SET_RESET);
        cur = SET_RESET;

        foreach (cases[i]) begin
            if (cases[i].setting != cur) begin
                wait_idle(SETTLE_CYCLES);
                cur = cases[i].setting;
                load_calibration(setting_cfg(cur));
            end
            pin_pt = '{x: cases[i].pin_x, y: cases[i].pin_y, z: cases[i].pin_z,
                       color: cases[i].px.color};
            send_pixel(cases[i].px, cases[i].pinned, cases[i].pin_keep, pin_pt, kept);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle(SETTLE_CYCLES);
            load_calibration(setting_cfg(SET_RANDOM));
            if (phase == RANDOM_PHASES - 1) begin
                src_gap_pct   = 0;
                snk_stall_pct = 0;
            end else begin
                src_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
                snk_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 25);
            end
            sent   = 0;
            kept_n = 0;
            while (kept_n < PHASE_KEPT && sent < PHASE_CAP) begin
                px.column    = 12'($urandom);
                px.row       = 12'($urandom);
                px.raw_depth = random_depth(cal.max_depth);
                px.color     = 24'($urandom);
                send_pixel(px, 1'b0, 1'b0, '0, kept);
                sent++;
                kept_n += kept;
                if (phase != RANDOM_PHASES - 1 && $urandom_range(0, 199) == 0) begin
                    wait_idle(0);
                end
            end
        end

        wait_idle(SETTLE_CYCLES);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
